[hw/rtl/hcbp_pkg.sv]
`default_nettype none
package hcbp_pkg;

  localparam int SYM_COUNT    = 256;
  localparam int SYM_W        = 8;
  localparam int ADDR_W       = $clog2(SYM_COUNT);
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BUF_W        = CODE_W + 7;
  localparam int FILL_W       = 6;
  localparam int TOTAL_W      = 32;
  localparam int QDEPTH       = 2;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  entry_length;
    logic [CODE_W-1:0] entry_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [3:0]         used_bits;
    logic               is_tail;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } table_entry_t;

  // job handed from front to back: flush, or encode of a masked code
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } job_t;

endpackage
`default_nettype wire

[hw/rtl/hcbp_front.sv]
`default_nettype none
module hcbp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire hcbp_pkg::in_item_t item,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output hcbp_pkg::job_t        job
);
  import hcbp_pkg::*;

  table_entry_t code_table [SYM_COUNT];
  table_entry_t rd_entry;

  logic s1_valid;
  logic s1_flush;
  logic s1_in_range;
  logic accept;
  logic in_range;
  logic is_write;
  logic is_job;
  logic [LEN_W-1:0] wr_len;
  logic [LEN_W-1:0] job_len;
  logic [CODE_W-1:0] mask;

  assign accept     = item_valid && item_ready;
  assign item_ready = !s1_valid || job_ready;
  assign in_range   = ({1'b0, item.symbol} < (SYM_W + 1)'(SYM_COUNT));
  assign is_write   = (item.cmd == CMD_WRITE);
  assign is_job     = (item.cmd == CMD_ENCODE) || (item.cmd == CMD_FLUSH);
  assign wr_len     = (item.entry_length > LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : item.entry_length;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (accept && is_write && in_range) begin
      code_table[item.symbol[ADDR_W-1:0]] <= '{length: wr_len, code: item.entry_code};
    end
    if (accept && (item.cmd == CMD_ENCODE)) begin
      rd_entry <= code_table[item.symbol[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_job;
    end else if (job_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush    <= (item.cmd == CMD_FLUSH);
      s1_in_range <= in_range;
    end
  end

  assign job_len = (s1_flush || !s1_in_range) ? '0 : rd_entry.length;

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      mask[i] = (LEN_W'(i) < job_len);
    end
  end

  assign job_valid    = s1_valid;
  assign job.is_flush = s1_flush;
  assign job.length   = job_len;
  assign job.code     = rd_entry.code & mask;

endmodule
`default_nettype wire

[hw/rtl/hcbp_queue.sv]
`default_nettype none
module hcbp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire hcbp_pkg::job_t push_job,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output hcbp_pkg::job_t      pop_job
);
  import hcbp_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic push;
  logic pop;

  assign push_ready = (fill != CNT_W'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/hcbp_back.sv]
`default_nettype none
module hcbp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire hcbp_pkg::job_t job,
  output logic                result_valid,
  input  wire logic           result_ready,
  output hcbp_pkg::out_item_t result
);
  import hcbp_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // pending bits, oldest in bit zero; fill below 8 while idle
  logic [BUF_W-1:0]   bits;
  logic [BUF_W-1:0]   bits_next;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic [TOTAL_W-1:0] count;
  logic [TOTAL_W-1:0] count_next;
  logic [TOTAL_W-1:0] count_inc;
  logic               out_free;
  logic               load;
  out_item_t          load_item;
  logic [BUF_W-1:0]   merged;
  logic [FILL_W-1:0]  merged_fill;

  assign out_free    = !result_valid || result_ready;
  assign count_inc   = (count == '1) ? count : count + 1'b1;
  assign merged      = bits | ({{(BUF_W - CODE_W){1'b0}}, job.code} << fill[2:0]);
  assign merged_fill = fill + job.length;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid && !job.is_flush && (merged_fill >= FILL_W'(8))) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && (fill < FILL_W'(16))) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready  = 1'b0;
    load       = 1'b0;
    load_item  = '0;
    bits_next  = bits;
    fill_next  = fill;
    count_next = count;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          if (job.is_flush) begin
            if (out_free) begin
              job_ready             = 1'b1;
              load                  = 1'b1;
              load_item.out_byte    = bits[7:0];
              load_item.used_bits   = fill[3:0];
              load_item.is_tail     = 1'b1;
              load_item.total_bytes = count_inc;
              load_item.last        = 1'b1;
              bits_next             = '0;
              fill_next             = '0;
              count_next            = '0;
            end
          end else begin
            job_ready = 1'b1;
            bits_next = merged;
            fill_next = merged_fill;
          end
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          load                  = 1'b1;
          load_item.out_byte    = bits[7:0];
          load_item.used_bits   = 4'd8;
          load_item.is_tail     = 1'b0;
          load_item.total_bytes = count_inc;
          load_item.last        = (fill < FILL_W'(16));
          bits_next             = bits >> 8;
          fill_next             = fill - FILL_W'(8);
          count_next            = count_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      bits         <= '0;
      fill         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      bits  <= bits_next;
      fill  <= fill_next;
      count <= count_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/huffman_code_bit_packer.sv]
// path: an encode passes the front stage register, the job queue, the bit accumulator
//   and the result register; a flush's tail byte skips the accumulator
// throughput: an encode yields 0 to 4 full bytes, emitted by the packer in the back end
//   at one byte per cycle while the result side does not stall
// reset: rst (synchronous, active high) clears accumulator, fill, byte count, queue and
//   valids; code table contents stay undefined until written
`default_nettype none
module huffman_code_bit_packer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire hcbp_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output hcbp_pkg::out_item_t      result
);
  import hcbp_pkg::*;

  // front to queue
  logic f_valid;
  logic f_ready;
  job_t f_job;

  // queue to back
  logic b_valid;
  logic b_ready;
  job_t b_job;

  // front end: table writes, table lookup, code masking
  hcbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job        (f_job)
  );

  // short job queue so lookups continue while the packer drains bytes
  hcbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  // back end: bit accumulator, byte emission, saturating byte count
  hcbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (b_valid),
    .job_ready    (b_ready),
    .job          (b_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

[sim/huffman_code_bit_packer_tb.sv]
`timescale 1ns / 100ps
module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  // idle cycles after the last pending byte before a drain-gated item goes out:
  //   an encode's path to its first byte plus up to 3 more bytes, with margin
  localparam int DRAIN_QUIET  = 12;
  localparam int RANDOM_ITEMS = 190;
  localparam int FLUSH_LIMIT  = 20000;

  // one queued transfer and whether it waits for the result side to go quiet
  typedef struct {
    in_item_t payload;
    bit       after_drain;
  } send_item_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  huffman_code_bit_packer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // packer model: code table, byte accumulator, fill level and byte count
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]   code_len_mdl  [SYM_COUNT];
  logic [CODE_W-1:0]  code_bits_mdl [SYM_COUNT];
  logic [7:0]         acc_byte = '0;
  int unsigned        acc_fill = 0;
  logic [TOTAL_W-1:0] byte_count = '0;

  // bytes the block still owes, oldest first
  out_item_t bytes_due[$];

  send_item_t items_to_send[$];
  int         queued_count = 0;
  int         sent_count   = 0;
  int         mismatches   = 0;

  // generator side bookkeeping so no symbol is encoded before its entry exists
  bit         sym_written [SYM_COUNT];
  logic [7:0] written_syms[$];

  function automatic void bump_byte_count();
    if (byte_count != {TOTAL_W{1'b1}})
      byte_count++;
  endfunction

  // works out the bytes one accepted transfer produces and queues them
  function automatic void predict_packed_bytes(input in_item_t it);
    logic [7:0]         full_bytes [4];
    logic [TOTAL_W-1:0] counts     [4];
    out_item_t          r;
    int                 n;
    logic [LEN_W-1:0]   len;
    logic [CODE_W-1:0]  bits;
    n = 0;
    case (it.cmd)
      CMD_WRITE: begin
        // overlong lengths clamp to the longest code
        code_len_mdl[it.symbol]  = (it.entry_length > MAX_CODE_LEN) ?
                                   LEN_W'(MAX_CODE_LEN) : it.entry_length;
        code_bits_mdl[it.symbol] = it.entry_code;
      end
      CMD_ENCODE: begin
        len  = code_len_mdl[it.symbol];
        bits = code_bits_mdl[it.symbol];
        for (int j = 0; j < int'(len); j++) begin
          if (bits[j])
            acc_byte[acc_fill] = 1'b1;
          acc_fill++;
          if (acc_fill == 8) begin
            bump_byte_count();
            if (n < 4) begin
              full_bytes[n] = acc_byte;
              counts[n]     = byte_count;
              n++;
            end
            acc_byte = '0;
            acc_fill = 0;
          end
        end
        for (int k = 0; k < n; k++) begin
          r.out_byte    = full_bytes[k];
          r.used_bits   = 4'd8;
          r.is_tail     = 1'b0;
          r.total_bytes = counts[k];
          r.last        = (k == n - 1);
          bytes_due     = {bytes_due, r};
        end
      end
      CMD_FLUSH: begin
        // tail byte goes out even when empty, then the stream restarts
        bump_byte_count();
        r.out_byte    = acc_byte;
        r.used_bits   = 4'(acc_fill);
        r.is_tail     = 1'b1;
        r.total_bytes = byte_count;
        r.last        = 1'b1;
        bytes_due     = {bytes_due, r};
        acc_byte   = '0;
        acc_fill   = 0;
        byte_count = '0;
      end
      default: ;  // unused command, no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // idle pattern: mostly no gap or a short one, now and then a long one,
  // plus calm stretches with no idling at all
  // ---------------------------------------------------------------------------
  function automatic int idle_length(inout int calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void push_item(input logic [1:0] cmd, input logic [7:0] sym,
                                    input logic [5:0] len, input logic [31:0] code,
                                    input bit after_drain);
    send_item_t s;
    s.payload.cmd          = cmd;
    s.payload.symbol       = sym;
    s.payload.entry_length = len;
    s.payload.entry_code   = code;
    s.after_drain          = after_drain;
    items_to_send          = {items_to_send, s};
  endfunction

  function automatic void add_write(input logic [7:0] sym, input logic [5:0] len,
                                    input logic [31:0] code);
    push_item(CMD_WRITE, sym, len, code, 1'b0);
    if (!sym_written[sym]) begin
      sym_written[sym] = 1'b1;
      written_syms     = {written_syms, sym};
    end
  endfunction

  // encode carries random junk in the fields it does not use
  function automatic void add_encode(input logic [7:0] sym);
    push_item(CMD_ENCODE, sym, 6'($urandom), $urandom, 1'b0);
  endfunction

  function automatic void add_flush(input bit after_drain);
    push_item(CMD_FLUSH, 8'($urandom), 6'($urandom), $urandom, after_drain);
  endfunction

  function automatic void add_noise();
    push_item(CMD_SPARE, 8'($urandom), 6'($urandom), $urandom, 1'b0);
  endfunction

  // random code length: mostly short codes, sometimes long or overlong
  function automatic logic [5:0] random_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 6'($urandom_range(1, 12));
    if (r < 90)
      return 6'($urandom_range(13, 32));
    if (r < 95)
      return 6'($urandom_range(33, 63));
    return 6'd0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued items, predicts on each accepted transfer
  // ---------------------------------------------------------------------------
  int       send_gap   = 0;
  int       send_calm  = 0;
  int       quiet_cycles = 0;
  send_item_t next_send;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      // how long the result side has had nothing outstanding
      if (bytes_due.size() == 0)
        quiet_cycles++;
      else
        quiet_cycles = 0;

      if (item_valid && item_ready) begin
        predict_packed_bytes(item);
        sent_count++;
        send_gap = idle_length(send_calm);
      end

      // payload may only change once the current one is gone
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (items_to_send.size() != 0 &&
                     (!items_to_send[0].after_drain || quiet_cycles >= DRAIN_QUIET)) begin
          next_send = items_to_send.pop_front();
          item       <= next_send.payload;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random backpressure and field-by-field compare
  // ---------------------------------------------------------------------------
  int        recv_stall = 0;
  int        recv_calm  = 0;
  out_item_t want;

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (bytes_due.size() == 0) begin
          $error("result transfer with nothing pending: out_byte %0h", result.out_byte);
          mismatches++;
        end else begin
          want = bytes_due.pop_front();
          check_field("out_byte",    32'(want.out_byte),    32'(result.out_byte));
          check_field("used_bits",   32'(want.used_bits),   32'(result.used_bits));
          check_field("is_tail",     32'(want.is_tail),     32'(result.is_tail));
          check_field("total_bytes", want.total_bytes,      result.total_bytes);
          check_field("last",        32'(want.last),        32'(result.last));
        end
      end

      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        recv_stall = idle_length(recv_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int          made;
    int unsigned r;
    int          waited;

    // empty flush right out of reset: zero byte, zero bits
    add_flush(1'b0);
    // entries covering zero length, full length, clamping and junk above length
    add_write(8'd0,   6'd0,  32'hFFFF_FFFF);
    add_write(8'd255, 6'd32, 32'hA5C3_F00F);
    add_write(8'd1,   6'd63, 32'h1234_5678);
    add_write(8'd2,   6'd7,  32'hDEAD_BE5A);
    add_write(8'd3,   6'd1,  32'h0000_0001);
    add_write(8'd128, 6'd33, 32'h0000_0000);
    add_encode(8'd0);    // zero length, nothing comes out
    add_encode(8'd2);    // 7 bits pending, no byte yet
    add_encode(8'd3);    // completes one byte
    add_encode(8'd255);  // exactly four bytes
    add_encode(8'd2);    // back to 7 pending
    add_encode(8'd255);  // 39 bits: four bytes, 7 left over
    add_encode(8'd1);    // clamped length
    add_encode(8'd128);  // clamped, all zero bits
    add_noise();         // unused command
    add_encode(8'd2);
    add_flush(1'b0);     // partial tail
    add_flush(1'b0);     // empty tail again
    add_encode(8'd3);
    add_flush(1'b1);     // sender holds until the result side is quiet
    add_write(8'd3, 6'd8, 32'hFFFF_FFFF);  // overwrite an entry
    add_encode(8'd3);
    add_flush(1'b0);

    // random part: mostly encodes of known symbols, with writes, flushes and noise
    made = 0;
    while (made < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_write(8'($urandom), random_length(), $urandom);
        made++;
      end else if (r < 82) begin
        add_encode(written_syms[$urandom_range(0, written_syms.size() - 1)]);
        made++;
      end else if (r < 93) begin
        add_flush(1'b0);
        made++;
      end else if (r < 96) begin
        add_flush(1'b1);
        made++;
      end else begin
        add_noise();
      end
    end
    add_flush(1'b0);
    queued_count = items_to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (sent_count == queued_count);
    waited = 0;
    while (bytes_due.size() != 0 && waited < FLUSH_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // let any stray output show up before judging
    repeat (20) @(posedge clk);
    if (bytes_due.size() != 0) begin
      $error("%0d expected result transfers never arrived", bytes_due.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
